### rtl/acuds_pkg.sv
// Shared types and constants for the dial sequencer.
// No dependencies; used by every module under rtl/.
package acuds_pkg;

  // Item kinds after classification in the front end
  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // Sequencer phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_READY     = 8'b0000_0010,
    PH_WAIT_PND  = 8'b0000_0100,
    PH_WAIT_DONE = 8'b0000_1000,
    PH_PAUSE     = 8'b0001_0000,
    PH_FLASH     = 8'b0010_0000,
    PH_CONN      = 8'b0100_0000,
    PH_FAIL      = 8'b1000_0000
  } phase_e;

  typedef enum logic [1:0] {
    OUT_DIALING = 2'd0,
    OUT_CONN    = 2'd1,
    OUT_FAIL    = 2'd2,
    OUT_IDLE    = 2'd3
  } outcome_e;

  // Register indexes on the configuration port
  localparam logic REG_PAUSE_TICKS = 1'b0;
  localparam logic REG_FLASH_TICKS = 1'b1;

  localparam logic [3:0] PAUSE_TICKS_RST = 4'd2;
  localparam logic [3:0] FLASH_TICKS_RST = 4'd1;

  // Control word bits
  localparam logic [15:0] BIT_CRQ = 16'h0001;
  localparam logic [15:0] BIT_DPR = 16'h0002;
  localparam logic [15:0] BIT_MEN = 16'h0004;
  localparam logic [15:0] BIT_IEN = 16'h0040;

  // Special held codes
  localparam logic [3:0] CODE_PAUSE = 4'd14;
  localparam logic [3:0] CODE_FLASH = 4'd15;

  // Dial character bytes outside the contiguous digit range
  localparam logic [7:0] CH_DIGIT_LO = 8'h30;
  localparam logic [7:0] CH_DIGIT_HI = 8'h3D;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_HASH     = 8'h23;
  localparam logic [7:0] CH_E        = 8'h65;
  localparam logic [7:0] CH_W        = 8'h77;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_F        = 8'h66;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic       last_char;
    logic       power_off;
    logic       abandon_call;
    logic       line_connected;
    logic       next_digit_wanted;
    logic       op_done;
  } in_item_t;

  typedef struct packed {
    logic        reg_write;
    logic [15:0] reg_value;
    logic        char_ready;
    logic [1:0]  outcome;
    logic        char_dropped;
  } out_item_t;

  // Classified item as queued between front and back
  typedef struct packed {
    kind_e      kind;
    logic [3:0] code;
    logic       skip;
    logic       last;
    logic       pwi;
    logic       acr;
    logic       dss;
    logic       pnd;
    logic       done;
  } cls_item_t;

  typedef struct packed {
    logic [3:0] pause_ticks;
    logic [3:0] flash_ticks;
  } cfg_t;

  function automatic logic [15:0] base_word(input logic crq);
    return BIT_IEN | BIT_MEN | (crq ? BIT_CRQ : 16'h0000);
  endfunction

endpackage

### rtl/acuds_front.sv
// Front end: decodes the item kind and maps dial characters to codes.
// Depends on acuds_pkg.
module acuds_front (
  input  acuds_pkg::in_item_t  item_i,
  output acuds_pkg::cls_item_t cls_o
);

  logic [7:0] ch;
  logic [3:0] code;
  logic       skip;

  assign ch = item_i.char_code;

  always_comb begin
    code = 4'd0;
    skip = 1'b0;
    if (ch >= acuds_pkg::CH_DIGIT_LO && ch <= acuds_pkg::CH_DIGIT_HI) begin
      code = ch[3:0];  // 0x30..0x3D -> 0..13
    end else begin
      case (ch)
        acuds_pkg::CH_STAR: code = 4'd10;
        acuds_pkg::CH_HASH: code = 4'd11;
        acuds_pkg::CH_E:    code = 4'd12;
        acuds_pkg::CH_W:    code = 4'd13;
        acuds_pkg::CH_DASH: code = acuds_pkg::CODE_PAUSE;
        acuds_pkg::CH_F:    code = acuds_pkg::CODE_FLASH;
        default:            skip = 1'b1;
      endcase
    end
  end

  always_comb begin
    cls_o.kind = acuds_pkg::kind_e'(item_i.func);
    cls_o.code = code;
    cls_o.skip = skip;
    cls_o.last = item_i.last_char;
    cls_o.pwi  = item_i.power_off;
    cls_o.acr  = item_i.abandon_call;
    cls_o.dss  = item_i.line_connected;
    cls_o.pnd  = item_i.next_digit_wanted;
    cls_o.done = item_i.op_done;
  end

endmodule

### rtl/acuds_queue.sv
// Short queue of classified transactions between front and back ends.
// Depends on acuds_pkg.
module acuds_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  acuds_pkg::cls_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output acuds_pkg::cls_item_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  acuds_pkg::cls_item_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == FullCnt);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/acuds_back.sv
// Back end: dial state machine, one queued transaction per cycle
// unless stalled, into an output register. Depends on acuds_pkg.
module acuds_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acuds_pkg::cfg_t      cfg_i,
  input  logic                 empty_i,
  input  acuds_pkg::cls_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output acuds_pkg::out_item_t out_data_o
);

  acuds_pkg::phase_e   phase_q, phase_d;
  logic [3:0]          held_q, held_d;
  logic [3:0]          tick_q, tick_d;
  logic                crq_q, crq_d;
  logic                ended_q, ended_d;
  logic                out_valid_q;
  acuds_pkg::out_item_t out_q, res;

  logic        terminal, take, wr, dropped, ready;
  logic [15:0] val;
  logic [1:0]  oc;

  assign pop_o       = !empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign terminal = (phase_q == acuds_pkg::PH_IDLE) || (phase_q == acuds_pkg::PH_CONN) ||
                    (phase_q == acuds_pkg::PH_FAIL);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    tick_d  = tick_q;
    crq_d   = crq_q;
    ended_d = ended_q;
    take    = 1'b0;
    wr      = 1'b0;
    val     = 16'h0000;
    dropped = 1'b0;
    case (item_i.kind)
      acuds_pkg::KIND_CHAR: begin
        if (terminal) begin
          // new session: raise call request first
          crq_d   = 1'b1;
          ended_d = 1'b0;
          wr      = 1'b1;
          val     = acuds_pkg::base_word(1'b1);
          phase_d = acuds_pkg::PH_READY;
          take    = 1'b1;
        end else if (phase_q == acuds_pkg::PH_READY && !ended_q) begin
          take = 1'b1;
        end else begin
          dropped = 1'b1;
        end
        if (take) begin
          if (item_i.last) ended_d = 1'b1;
          if (!item_i.skip) begin
            held_d  = item_i.code;
            phase_d = acuds_pkg::PH_WAIT_PND;
          end
        end
      end
      acuds_pkg::KIND_STATUS: begin
        if (!terminal) begin
          if (item_i.pwi || item_i.acr) begin
            phase_d = acuds_pkg::PH_FAIL;
          end else if (item_i.dss) begin
            phase_d = acuds_pkg::PH_CONN;
          end else if (phase_q == acuds_pkg::PH_WAIT_PND && item_i.pnd) begin
            if (held_q == acuds_pkg::CODE_PAUSE) begin
              tick_d  = cfg_i.pause_ticks;
              phase_d = acuds_pkg::PH_PAUSE;
            end else if (held_q == acuds_pkg::CODE_FLASH) begin
              crq_d   = 1'b0;
              wr      = 1'b1;
              val     = acuds_pkg::base_word(1'b0);
              tick_d  = cfg_i.flash_ticks;
              phase_d = acuds_pkg::PH_FLASH;
            end else begin
              crq_d   = 1'b1;
              wr      = 1'b1;
              val     = {4'h0, held_q, 8'h00} | acuds_pkg::base_word(1'b1) |
                        acuds_pkg::BIT_DPR;
              phase_d = acuds_pkg::PH_WAIT_DONE;
            end
          end else if (phase_q == acuds_pkg::PH_WAIT_DONE && item_i.done) begin
            wr      = 1'b1;
            val     = acuds_pkg::base_word(crq_q);
            phase_d = acuds_pkg::PH_READY;
          end
        end
      end
      acuds_pkg::KIND_TICK: begin
        if (phase_q == acuds_pkg::PH_PAUSE || phase_q == acuds_pkg::PH_FLASH) begin
          // a count of zero finishes on the first tick, as one does
          if (tick_q <= 4'd1) begin
            tick_d = 4'd0;
            if (phase_q == acuds_pkg::PH_FLASH) begin
              crq_d = 1'b1;
              wr    = 1'b1;
              val   = acuds_pkg::base_word(1'b1);
            end
            phase_d = acuds_pkg::PH_READY;
          end else begin
            tick_d = tick_q - 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (phase_d == acuds_pkg::PH_IDLE) oc = acuds_pkg::OUT_IDLE;
    else if (phase_d == acuds_pkg::PH_CONN) oc = acuds_pkg::OUT_CONN;
    else if (phase_d == acuds_pkg::PH_FAIL) oc = acuds_pkg::OUT_FAIL;
    else oc = acuds_pkg::OUT_DIALING;
    ready = (phase_d == acuds_pkg::PH_IDLE) || (phase_d == acuds_pkg::PH_CONN) ||
            (phase_d == acuds_pkg::PH_FAIL) ||
            (phase_d == acuds_pkg::PH_READY && !ended_d);
    res.reg_write    = wr;
    res.reg_value    = val;
    res.char_ready   = ready;
    res.outcome      = oc;
    res.char_dropped = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= acuds_pkg::PH_IDLE;
      held_q      <= 4'd0;
      tick_q      <= 4'd0;
      crq_q       <= 1'b0;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        tick_q  <= tick_d;
        crq_q   <= crq_d;
        ended_q <= ended_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule

### rtl/acu_dial_sequencer.sv
// Top level of the dial sequencer: configuration registers and the
// front end / queue / back end chain. Depends on acuds_pkg and all acuds_* modules.
//
// Drives an automatic calling unit through a dial string. Each input
// transaction (a dial character, a status snapshot of the unit or a one-second
// tick) yields exactly one result transaction carrying the control word to
// write, whether a new character can be taken, the session outcome and a
// dropped-character flag. The front end classifies a transaction in the cycle
// it is accepted and places it in a short queue (QDepth entries); the back end
// takes one queued transaction per cycle through the dial state machine into an
// output register while that register is not stalled. Sustained rate is one
// transaction per clock while the result side does not stall; a result is
// registered in the queue and then in the output register before it is valid.
// in_stall_o rises only when the queue is full, which happens only while the
// result side is stalled. Pause and flash tick counts are set through the APB
// port: pause_ticks at byte address 0, flash_ticks at 4 (4 bits each, zero
// acts as one). Write them only while the block is idle. The unit's own
// open/close, probing and unit selection are outside this block.
module acu_dial_sequencer #(
  parameter int unsigned QDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  acuds_pkg::in_item_t  in_data_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output acuds_pkg::out_item_t out_data_o,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  acuds_pkg::cfg_t      cfg_q;
  acuds_pkg::cls_item_t cls, q_data;
  logic                 q_full, q_empty, q_pop, push;
  logic                 reg_sel;
  logic                 cfg_wr;

  // ---- configuration registers ----
  // Register select is paddr[2]; the byte offset bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_sel)
      acuds_pkg::REG_PAUSE_TICKS: prdata = {28'h0, cfg_q.pause_ticks};
      default:                    prdata = {28'h0, cfg_q.flash_ticks};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pause_ticks <= acuds_pkg::PAUSE_TICKS_RST;
      cfg_q.flash_ticks <= acuds_pkg::FLASH_TICKS_RST;
    end else if (cfg_wr) begin
      if (reg_sel == acuds_pkg::REG_PAUSE_TICKS) begin
        cfg_q.pause_ticks <= pwdata[3:0];
      end else begin
        cfg_q.flash_ticks <= pwdata[3:0];
      end
    end
  end

  // ---- front end: accept and classify ----
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  acuds_front u_front (
    .item_i (in_data_i),
    .cls_o  (cls)
  );

  // ---- decoupling queue ----
  acuds_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_data)
  );

  // ---- back end: state machine and result register ----
  acuds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .item_i      (q_data),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### dv/acuds_dial_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the dial sequencer: predicts one result per accepted input
// transaction and compares it with the result channel. Depends on acuds_pkg.
module acuds_dial_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  acuds_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  acuds_pkg::out_item_t out_data_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic                 final_check_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  import acuds_pkg::*;

  localparam logic [3:0] DIG_STAR = 4'd10;
  localparam logic [3:0] DIG_HASH = 4'd11;
  localparam logic [3:0] DIG_E    = 4'd12;
  localparam logic [3:0] DIG_W    = 4'd13;

  // shadow of the sequencer
  phase_e     cur_phase;
  logic [3:0] held_code;
  logic [3:0] ticks_left;
  logic       crq_on;
  logic       string_done;
  logic [3:0] pause_cfg;
  logic [3:0] flash_cfg;

  out_item_t   expected_q[$];
  int unsigned errors = 0;
  int unsigned pending;
  bit          final_seen;

  assign fail_count_o = errors;
  assign pending_o    = pending;

  function automatic logic [15:0] control_word(input logic crq);
    return BIT_IEN | BIT_MEN | (crq ? BIT_CRQ : 16'h0000);
  endfunction

  // returns 0 for characters that are skipped
  function automatic logic dial_code(input logic [7:0] ch, output logic [3:0] code);
    logic [7:0] offset;
    offset = ch - CH_DIGIT_LO;
    code   = offset[3:0];
    if (ch >= CH_DIGIT_LO && ch <= CH_DIGIT_HI) return 1'b1;
    case (ch)
      CH_STAR: code = DIG_STAR;
      CH_HASH: code = DIG_HASH;
      CH_E:    code = DIG_E;
      CH_W:    code = DIG_W;
      CH_DASH: code = CODE_PAUSE;
      CH_F:    code = CODE_FLASH;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic out_item_t dial_step(input in_item_t it);
    out_item_t  r;
    logic [3:0] code;
    logic       take;
    logic       terminal;
    r        = '0;
    take     = 1'b0;
    terminal = (cur_phase == PH_IDLE) || (cur_phase == PH_CONN) || (cur_phase == PH_FAIL);
    case (kind_e'(it.func))
      KIND_CHAR: begin
        if (terminal) begin
          // new session
          crq_on      = 1'b1;
          string_done = 1'b0;
          r.reg_write = 1'b1;
          r.reg_value = control_word(1'b1);
          cur_phase   = PH_READY;
          take        = 1'b1;
        end else if (cur_phase == PH_READY && !string_done) begin
          take = 1'b1;
        end else begin
          r.char_dropped = 1'b1;
        end
        if (take) begin
          if (it.last_char) string_done = 1'b1;
          if (dial_code(it.char_code, code)) begin
            held_code = code;
            cur_phase = PH_WAIT_PND;
          end
        end
      end
      KIND_STATUS: begin
        if (!terminal) begin
          if (it.power_off || it.abandon_call) begin
            cur_phase = PH_FAIL;
          end else if (it.line_connected) begin
            cur_phase = PH_CONN;
          end else if (cur_phase == PH_WAIT_PND && it.next_digit_wanted) begin
            if (held_code == CODE_PAUSE) begin
              ticks_left = pause_cfg;
              cur_phase  = PH_PAUSE;
            end else if (held_code == CODE_FLASH) begin
              crq_on      = 1'b0;
              r.reg_write = 1'b1;
              r.reg_value = control_word(1'b0);
              ticks_left  = flash_cfg;
              cur_phase   = PH_FLASH;
            end else begin
              crq_on      = 1'b1;
              r.reg_write = 1'b1;
              r.reg_value = {4'h0, held_code, 8'h00} | BIT_IEN | BIT_MEN | BIT_DPR | BIT_CRQ;
              cur_phase   = PH_WAIT_DONE;
            end
          end else if (cur_phase == PH_WAIT_DONE && it.op_done) begin
            r.reg_write = 1'b1;
            r.reg_value = control_word(crq_on);
            cur_phase   = PH_READY;
          end
        end
      end
      KIND_TICK: begin
        if (cur_phase == PH_PAUSE || cur_phase == PH_FLASH) begin
          // a count of zero behaves as one
          if (ticks_left <= 4'd1) begin
            ticks_left = 4'd0;
            if (cur_phase == PH_FLASH) begin
              crq_on      = 1'b1;
              r.reg_write = 1'b1;
              r.reg_value = control_word(1'b1);
            end
            cur_phase = PH_READY;
          end else begin
            ticks_left = ticks_left - 4'd1;
          end
        end
      end
      default: ;
    endcase
    case (cur_phase)
      PH_IDLE: r.outcome = OUT_IDLE;
      PH_CONN: r.outcome = OUT_CONN;
      PH_FAIL: r.outcome = OUT_FAIL;
      default: r.outcome = OUT_DIALING;
    endcase
    r.char_ready = (cur_phase == PH_IDLE) || (cur_phase == PH_CONN) ||
                   (cur_phase == PH_FAIL) || (cur_phase == PH_READY && !string_done);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cur_phase   = PH_IDLE;
      held_code   = 4'd0;
      ticks_left  = 4'd0;
      crq_on      = 1'b0;
      string_done = 1'b0;
      pause_cfg   = PAUSE_TICKS_RST;
      flash_cfg   = FLASH_TICKS_RST;
      final_seen  = 1'b0;
      expected_q.delete();
      pending    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_PAUSE_TICKS: pause_cfg = pwdata_i[3:0];
          REG_FLASH_TICKS: flash_cfg = pwdata_i[3:0];
          default: ;
        endcase
      end
      // pop before push: a result never belongs to a same-edge input
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected: reg_value 0x%0h",
                 out_data_i.reg_value);
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("reg_write", want.reg_write, out_data_i.reg_write);
          check_field("reg_value", want.reg_value, out_data_i.reg_value);
          check_field("char_ready", want.char_ready, out_data_i.char_ready);
          check_field("outcome", want.outcome, out_data_i.outcome);
          check_field("char_dropped", want.char_dropped, out_data_i.char_dropped);
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(dial_step(in_data_i));
      if (final_check_i && !final_seen) begin
        final_seen = 1'b1;
        if (expected_q.size() != 0) begin
          $error("%0d expected result transactions never arrived", expected_q.size());
          errors++;
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

### dv/acu_dial_sequencer_tb.sv
`timescale 1ns / 100ps
// Top of the dial sequencer testbench: clock, reset, stimulus and verdict.
// Depends on acuds_pkg, the acu_dial_sequencer RTL and acuds_dial_checker.
module acu_dial_sequencer_tb;
  import acuds_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  localparam int unsigned WORK_ITEMS    = 1900;
  localparam int unsigned N_PHASES      = 6;
  localparam int unsigned LONG_HOLD     = 300;   // receiver hold-off that fills the queue
  localparam int unsigned SETTLE_CYCLES = 6;     // margin for the pipeline to settle
  localparam int unsigned IDLE_LIMIT    = 3000;  // cycles without any transaction

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        final_check = 1'b0;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus bookkeeping
  int unsigned work_done = 0;      // transactions that the block acts on
  bit          burst = 1'b0;       // no sender gaps while set
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned pause_n = PAUSE_TICKS_RST;
  int unsigned flash_n = FLASH_TICKS_RST;

  always #(HALF_PERIOD) clk = ~clk;

  acu_dial_sequencer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  acuds_dial_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .final_check_i (final_check),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // ---------------------------------------------------------------------
  // Transaction builders. Fields that the item kind does not use carry
  // random junk, so every input bit toggles without affecting behaviour.
  // ---------------------------------------------------------------------
  function automatic in_item_t junk_item();
    logic [$bits(in_item_t)-1:0] raw;
    raw = $bits(in_item_t)'($urandom);
    return raw;
  endfunction

  function automatic in_item_t char_item(input logic [7:0] ch, input logic last);
    in_item_t it;
    it           = junk_item();
    it.func      = KIND_CHAR;
    it.char_code = ch;
    it.last_char = last;
    return it;
  endfunction

  function automatic in_item_t status_item(input logic pwi, input logic acr, input logic dss,
                                           input logic pnd, input logic done);
    in_item_t it;
    it                   = junk_item();
    it.func              = KIND_STATUS;
    it.power_off         = pwi;
    it.abandon_call      = acr;
    it.line_connected    = dss;
    it.next_digit_wanted = pnd;
    it.op_done           = done;
    return it;
  endfunction

  function automatic in_item_t tick_item();
    in_item_t it;
    it      = junk_item();
    it.func = KIND_TICK;
    return it;
  endfunction

  // snapshot that closes a session: at least one of PWI, ACR and DSS
  function automatic in_item_t end_status_item();
    logic [2:0] sel;
    sel = 3'($urandom_range(1, 7));
    return status_item(sel[2], sel[1], sel[0], 1'($urandom), 1'($urandom));
  endfunction

  // any of the fourteen digit characters or the four alternates
  function automatic logic [7:0] digit_char();
    int unsigned n;
    n = $urandom_range(0, 17);
    case (n)
      14:      return CH_STAR;
      15:      return CH_HASH;
      16:      return CH_E;
      17:      return CH_W;
      default: return CH_DIGIT_LO + 8'(n);
    endcase
  endfunction

  // mostly back to back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Called just after a rising edge; returns just after the edge
  // at which the transaction was taken. Valid stays high into the next
  // call when no gap is picked, so it is never lowered and raised in one
  // step.
  // ---------------------------------------------------------------------
  task automatic send(input in_item_t it, input bit counted);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (counted) work_done++;
  endtask

  // stray transaction: random kind, terminating bits mostly clear
  task automatic send_noise();
    in_item_t it;
    it = junk_item();
    if ($urandom_range(0, 9) != 0) begin
      it.power_off      = 1'b0;
      it.abandon_call   = 1'b0;
      it.line_connected = 1'b0;
    end
    send(it, 1'b0);
  endtask

  // hold the sender until every expected result is back, then let the
  // pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access; psel is left high so writes can run back to back
  task automatic apb_write(input logic idx, input logic [3:0] value);
    logic [31:0] word;
    word       = $urandom;
    word[3:0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic apply_config(input logic [3:0] p, input logic [3:0] f);
    apb_write(REG_PAUSE_TICKS, p);
    apb_write(REG_FLASH_TICKS, f);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // a zero count acts as one tick
    pause_n = (p == 4'd0) ? 1 : p;
    flash_n = (f == 4'd0) ? 1 : f;
  endtask

  // ---------------------------------------------------------------------
  // One dial session: a string of characters, each followed by the status
  // traffic a well-behaved unit would give, with noise mixed in and the
  // occasional session cut short by a terminating snapshot.
  // ---------------------------------------------------------------------
  task automatic dial_session();
    int unsigned n_chars;
    int unsigned sel;
    int unsigned i;
    logic [7:0]  ch;
    n_chars = $urandom_range(1, 8);
    burst   = ($urandom_range(0, 3) == 0);
    for (i = 0; i < n_chars; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) ch = digit_char();
      else if (sel < 72) ch = CH_DASH;
      else if (sel < 84) ch = CH_F;
      else ch = 8'($urandom);
      if ($urandom_range(0, 11) == 0) send_noise();
      send(char_item(ch, i == n_chars - 1), 1'b1);
      if ($urandom_range(0, 7) == 0) send(status_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b0), 1'b0);
      send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'($urandom)), 1'b1);
      // broken sequence: end mid-character, possibly during a flash
      if ($urandom_range(0, 24) == 0) begin
        send(end_status_item(), 1'b1);
        return;
      end
      if (sel >= 60 && sel < 72) begin
        repeat (pause_n) send(tick_item(), 1'b1);
      end else if (sel >= 72 && sel < 84) begin
        repeat (flash_n) send(tick_item(), 1'b1);
      end else begin
        if ($urandom_range(0, 9) == 0) send(tick_item(), 1'b0);
        send(status_item(1'b0, 1'b0, 1'b0, 1'($urandom), 1'b1), 1'b1);
      end
    end
    // a character after the end of the string is dropped
    if ($urandom_range(0, 4) == 0) send(char_item(8'($urandom), 1'($urandom)), 1'b1);
    send(end_status_item(), 1'b1);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stall pattern counted out in its own process. Short passes
  // and short stalls are most common, with long passes, a few long stalls,
  // and once a long hold-off that backs the block up into its input.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned rx_left;
    int unsigned r;
    rx_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_left != 0) begin
        rx_left--;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        rx_left   = LONG_HOLD - 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          out_stall <= 1'b0;
          rx_left   = $urandom_range(0, 4);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          rx_left   = $urandom_range(40, 120);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          rx_left   = $urandom_range(0, 2);
        end else begin
          out_stall <= 1'b1;
          rx_left   = $urandom_range(15, 50);
        end
      end
    end
  end

  // watchdog: ends the run if nothing moves on any channel for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("acu_dial_sequencer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned ph;
    int unsigned target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset configuration (pause 2, flash 1).
    // Stray transactions while idle: tick, snapshot with every bit, kind 3.
    send(tick_item(), 1'b0);
    send(status_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1), 1'b0);
    begin
      in_item_t it;
      it      = junk_item();
      it.func = KIND_NONE;
      send(it, 1'b0);
    end
    // session start on a digit; PND with DONE, then DONE
    send(char_item(CH_DIGIT_LO, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b1), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b1);
    // unmapped character, skipped at once
    send(char_item(8'h00, 1'b0), 1'b1);
    // pause over two ticks
    send(char_item(CH_DASH, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    send(tick_item(), 1'b1);
    send(tick_item(), 1'b1);
    // flash over one tick
    send(char_item(CH_F, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    send(tick_item(), 1'b1);
    // character while waiting for PND is dropped
    send(char_item(CH_W, 1'b0), 1'b1);
    send(char_item(CH_DIGIT_LO + 8'd9, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b1);
    // last character, then one more that is dropped
    send(char_item(CH_HASH, 1'b1), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b1, 1'b0), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1), 1'b1);
    send(char_item(CH_DIGIT_LO + 8'd1, 1'b0), 1'b1);
    // PWI wins over DSS
    send(status_item(1'b1, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);
    // restart from failure on a skipped last character, then connect
    send(char_item(8'hFF, 1'b1), 1'b1);
    send(status_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0), 1'b1);

    // Random part in several configuration phases, extremes and zero
    // counts among them; each phase starts from a drained block.
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      case (ph)
        0:       apply_config(4'd15, 4'd15);
        1:       apply_config(4'd0, 4'd0);
        2:       apply_config(4'd1, 4'd15);
        3:       apply_config(4'd15, 4'd1);
        4:       apply_config(4'd1, 4'd1);
        default: apply_config(4'($urandom), 4'($urandom));
      endcase
      if (ph == 0) long_hold_req = 1'b1;
      target = work_done + WORK_ITEMS / N_PHASES;
      while (work_done < target) dial_session();
    end

    // wind down: every expectation met, then let the pipeline settle
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    final_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("acu_dial_sequencer: match");
    else
      $display("acu_dial_sequencer: mismatch");
    $finish;
  end

endmodule
